### rtl/strmq_pkg.sv
// Shared types and codes for the sparse-table range-minimum engine.
package strmq_pkg;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_BUILD = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BCHK,
        S_BRDA,
        S_BRDB,
        S_BCMP,
        S_QLOG,
        S_QRDA,
        S_QRDB,
        S_QCMP,
        S_POST
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic hold_en;
        logic wr_en;
        logic wr_min;
    } tbl_ctrl_t;

endpackage

### rtl/strmq_table.sv
// Level table memory with registered read port, hold register and the shared min unit.
module strmq_table #(
    parameter int LEVELS     = 11,
    parameter int IDX_BITS   = 10,
    parameter int ADDR_BITS  = 14,
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  strmq_pkg::tbl_ctrl_t         ctrl,
    input  logic [ADDR_BITS-1:0]         rd_addr,
    input  logic [ADDR_BITS-1:0]         wr_addr,
    input  logic signed [VALUE_BITS-1:0] load_value,
    output logic signed [VALUE_BITS-1:0] min_value
);

    localparam int MEM_WORDS = LEVELS * (2 ** IDX_BITS);

    logic signed [VALUE_BITS-1:0] mem [MEM_WORDS];
    logic signed [VALUE_BITS-1:0] rd_data_reg;
    logic signed [VALUE_BITS-1:0] hold_reg;
    logic signed [VALUE_BITS-1:0] wr_data;

    // Compare the held first operand against the freshly read second one.
    assign min_value = (hold_reg < rd_data_reg) ? hold_reg : rd_data_reg;
    assign wr_data   = ctrl.wr_min ? min_value : load_value;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (ctrl.hold_en)
        begin
            hold_reg <= rd_data_reg;
        end
    end

endmodule

### rtl/sparse_table_range_min.sv
// Top level of the sparse-table range-minimum engine: sequencer, ports and output register.
//
//  channel  | handshake               | payload (lowest bit first)
//  ---------+-------------------------+----------------------------------------------------
//  in       | s_tvalid / s_tready     | s_tdata: element_index[9:0], element_value[41:10],
//           |                         |   left_index[51:42], right_index[61:52], zero pad
//           |                         | s_tuser: action[1:0]
//  out      | m_tvalid / m_tready     | m_tdata: minimum_value[31:0]; m_tuser: is_answer[0]
//  cfg      | cfg_valid / cfg_ready   | cfg_data: element_count[10:0]
//
// One beat is worked on at a time; s_tready is high only while the sequencer idles.
// A load or unknown action goes from idle through the post step to the output register.
// A query finds k = floor(log2(span)) capped at LEVELS-1 by shifting the span one bit
// per cycle, then reads the two entries through the single memory read port and
// compares them. A build checks, reads two entries and writes each built entry, and
// checks once more to step up each level; all reads go through the one read port.
// The table is not cleared by reset; entries hold garbage until loaded or built.
// A finished beat waits in the output register while the next beat is accepted; a stall
// on m_tready holds the sequencer only at its final step.
module sparse_table_range_min #(
    parameter int DEPTH      = 1024,
    parameter int LEVELS     = 11,
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // element_index, element_value, left_index, right_index
    input  logic [1:0]  s_tuser,    // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // minimum_value
    output logic [0:0]  m_tuser,    // is_answer
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data    // element_count
);

    localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SPAN_BITS = IDX_BITS + 1;
    localparam int LVL_BITS  = $clog2(LEVELS + 1);
    localparam int ADDR_BITS = LVL_BITS + IDX_BITS;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int SUM_BITS  = ((CNT_BITS > LEVELS) ? CNT_BITS : LEVELS) + 1;

    // Unpack the input beat.
    logic [1:0]         action;
    logic [9:0]         element_index;
    logic signed [31:0] element_value;
    logic [9:0]         left_index;
    logic [9:0]         right_index;

    assign action        = s_tuser;
    assign element_index = s_tdata[9:0];
    assign element_value = s_tdata[41:10];
    assign left_index    = s_tdata[51:42];
    assign right_index   = s_tdata[61:52];

    strmq_pkg::state_t    state_reg, state_next;
    logic [10:0]          element_count_reg;
    logic [LVL_BITS-1:0]  lvl_reg, lvl_next;
    logic [IDX_BITS-1:0]  idx_reg, idx_next;
    logic [IDX_BITS-1:0]  lo_reg, lo_next;
    logic [IDX_BITS-1:0]  hi_reg, hi_next;
    logic [SPAN_BITS-1:0] span_reg, span_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [31:0]          res_value_reg, res_value_next;
    logic                 res_answer_reg, res_answer_next;
    logic                 m_tvalid_reg;
    logic [31:0]          m_tdata_reg;
    logic                 m_tuser_reg;

    strmq_pkg::tbl_ctrl_t         ctrl;
    logic [ADDR_BITS-1:0]         rd_addr;
    logic [ADDR_BITS-1:0]         wr_addr;
    logic signed [VALUE_BITS-1:0] load_value;
    logic signed [VALUE_BITS-1:0] min_value;

    logic                 accept;
    logic                 out_free;
    logic [IDX_BITS-1:0]  left_c;
    logic [IDX_BITS-1:0]  right_c;
    logic [SUM_BITS-1:0]  len_w;
    logic [SUM_BITS-1:0]  fit_sum;
    logic                 build_done;
    logic                 build_fit;
    logic [IDX_BITS-1:0]  half_idx;
    logic [SPAN_BITS-1:0] off_w;
    logic                 log_more;
    logic                 load_in_range;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Saturate query bounds to the last table position.
    assign left_c  = (32'(left_index) >= DEPTH) ? IDX_BITS'(DEPTH - 1) : IDX_BITS'(left_index);
    assign right_c = (32'(right_index) >= DEPTH) ? IDX_BITS'(DEPTH - 1) : IDX_BITS'(right_index);
    assign load_in_range = (32'(element_index) < DEPTH);
    assign load_value    = VALUE_BITS'(element_value);

    // Build bookkeeping: block length at the current level and the fit test.
    assign len_w      = SUM_BITS'(1) << lvl_reg;
    assign fit_sum    = SUM_BITS'(idx_reg) + len_w;
    assign build_done = (lvl_reg == LVL_BITS'(LEVELS)) || (len_w > SUM_BITS'(cnt_reg));
    assign build_fit  = fit_sum <= SUM_BITS'(cnt_reg);
    assign half_idx   = idx_reg + IDX_BITS'(len_w >> 1);

    // Query: keep shifting while another leading bit remains and the level fits.
    assign log_more = ((span_reg >> 1) != '0) && (lvl_reg < LVL_BITS'(LEVELS - 1));
    assign off_w    = SPAN_BITS'(hi_reg) + SPAN_BITS'(1) - (SPAN_BITS'(1) << lvl_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            strmq_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (action)
                        strmq_pkg::ACT_BUILD: state_next = strmq_pkg::S_BCHK;
                        strmq_pkg::ACT_QUERY: state_next = strmq_pkg::S_QLOG;
                        default:              state_next = strmq_pkg::S_POST;
                    endcase
                end
            end
            strmq_pkg::S_BCHK:
            begin
                if (build_done)
                begin
                    state_next = strmq_pkg::S_POST;
                end
                else if (build_fit)
                begin
                    state_next = strmq_pkg::S_BRDA;
                end
            end
            strmq_pkg::S_BRDA: state_next = strmq_pkg::S_BRDB;
            strmq_pkg::S_BRDB: state_next = strmq_pkg::S_BCMP;
            strmq_pkg::S_BCMP: state_next = strmq_pkg::S_BCHK;
            strmq_pkg::S_QLOG:
            begin
                if (!log_more)
                begin
                    state_next = strmq_pkg::S_QRDA;
                end
            end
            strmq_pkg::S_QRDA: state_next = strmq_pkg::S_QRDB;
            strmq_pkg::S_QRDB: state_next = strmq_pkg::S_QCMP;
            strmq_pkg::S_QCMP: state_next = strmq_pkg::S_POST;
            strmq_pkg::S_POST:
            begin
                if (out_free)
                begin
                    state_next = strmq_pkg::S_IDLE;
                end
            end
            default: state_next = strmq_pkg::S_IDLE;
        endcase
    end

    // Memory control, addresses and input ready.
    always_comb
    begin
        s_tready = (state_reg == strmq_pkg::S_IDLE);
        ctrl     = '0;
        rd_addr  = '0;
        wr_addr  = '0;
        case (state_reg)
            strmq_pkg::S_IDLE:
            begin
                if (s_tvalid && (action == strmq_pkg::ACT_LOAD) && load_in_range)
                begin
                    ctrl.wr_en = 1'b1;
                    wr_addr    = {LVL_BITS'(0), IDX_BITS'(element_index)};
                end
            end
            strmq_pkg::S_BRDA:
            begin
                ctrl.rd_en = 1'b1;
                rd_addr    = {lvl_reg - LVL_BITS'(1), idx_reg};
            end
            strmq_pkg::S_BRDB:
            begin
                ctrl.rd_en   = 1'b1;
                ctrl.hold_en = 1'b1;
                rd_addr      = {lvl_reg - LVL_BITS'(1), half_idx};
            end
            strmq_pkg::S_BCMP:
            begin
                ctrl.wr_en  = 1'b1;
                ctrl.wr_min = 1'b1;
                wr_addr     = {lvl_reg, idx_reg};
            end
            strmq_pkg::S_QRDA:
            begin
                ctrl.rd_en = 1'b1;
                rd_addr    = {lvl_reg, lo_reg};
            end
            strmq_pkg::S_QRDB:
            begin
                ctrl.rd_en   = 1'b1;
                ctrl.hold_en = 1'b1;
                rd_addr      = {lvl_reg, IDX_BITS'(off_w)};
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    // Working registers of the sequencer.
    always_comb
    begin
        lvl_next        = lvl_reg;
        idx_next        = idx_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        span_next       = span_reg;
        cnt_next        = cnt_reg;
        res_value_next  = res_value_reg;
        res_answer_next = res_answer_reg;
        case (state_reg)
            strmq_pkg::S_IDLE:
            begin
                // Order the bounds, clamp the build count, clear the result.
                if (left_c <= right_c)
                begin
                    lo_next = left_c;
                    hi_next = right_c;
                end
                else
                begin
                    lo_next = right_c;
                    hi_next = left_c;
                end
                span_next = SPAN_BITS'(hi_next) - SPAN_BITS'(lo_next) + SPAN_BITS'(1);
                cnt_next  = (32'(element_count_reg) > DEPTH) ? CNT_BITS'(DEPTH)
                                                             : CNT_BITS'(element_count_reg);
                lvl_next  = (action == strmq_pkg::ACT_BUILD) ? LVL_BITS'(1) : LVL_BITS'(0);
                idx_next  = '0;
                res_value_next  = '0;
                res_answer_next = 1'b0;
            end
            strmq_pkg::S_BCHK:
            begin
                if (!build_done && !build_fit)
                begin
                    lvl_next = lvl_reg + LVL_BITS'(1);
                    idx_next = '0;
                end
            end
            strmq_pkg::S_BCMP:
            begin
                idx_next = idx_reg + IDX_BITS'(1);
            end
            strmq_pkg::S_QLOG:
            begin
                if (log_more)
                begin
                    lvl_next  = lvl_reg + LVL_BITS'(1);
                    span_next = span_reg >> 1;
                end
            end
            strmq_pkg::S_QCMP:
            begin
                res_value_next  = 32'(min_value);
                res_answer_next = 1'b1;
            end
            default:
            begin
                lvl_next = lvl_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= strmq_pkg::S_IDLE;
            element_count_reg <= 11'd1;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                element_count_reg <= cfg_data;
            end
            if ((state_reg == strmq_pkg::S_POST) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        lvl_reg        <= lvl_next;
        idx_reg        <= idx_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        span_reg       <= span_next;
        cnt_reg        <= cnt_next;
        res_value_reg  <= res_value_next;
        res_answer_reg <= res_answer_next;
        if ((state_reg == strmq_pkg::S_POST) && out_free)
        begin
            m_tdata_reg <= res_value_reg;
            m_tuser_reg <= res_answer_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    strmq_table #(
        .LEVELS     (LEVELS),
        .IDX_BITS   (IDX_BITS),
        .ADDR_BITS  (ADDR_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_table (
        .clk        (clk),
        .ctrl       (ctrl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .load_value (load_value),
        .min_value  (min_value)
    );

    // One beat in flight: an accepted beat drops ready on the next cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input accepted while a beat is still in work");

    // Build reads always come from an existing level below the one being written.
    a_build_level: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == strmq_pkg::S_BRDA) |->
            (lvl_reg != LVL_BITS'(0)) && (lvl_reg < LVL_BITS'(LEVELS)))
        else $error("build reads outside the level range");

    // The chosen query block never runs past the upper bound.
    a_query_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == strmq_pkg::S_QRDA) |->
            (SUM_BITS'(lo_reg) + len_w <= SUM_BITS'(hi_reg) + SUM_BITS'(1)))
        else $error("query level too large for the span");

    // A posted result reaches the output register on the next cycle.
    a_post_lands: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == strmq_pkg::S_POST) && out_free) |=> m_tvalid_reg)
        else $error("posted result did not reach the output");

endmodule
